// File: design/mlpf_pkg.sv
// mlpf_pkg: types and constants shared by the MLP inference block.
// No dependencies.
package mlpf_pkg;
  localparam int MAX_LAYERS = 4;
  localparam int MAX_WIDTH  = 16;
  localparam int DATA_WIDTH = 16;

  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH_0 = 3'd2;
  localparam logic [2:0] REG_OUT_WIDTH_3 = 3'd5;

  localparam int FRAC_BITS = 8;

  // request handed from the front end to the back end
  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  layer_sel;
    logic [3:0]  node_sel;
    logic [3:0]  elem_index;
    logic [15:0] value;
    logic        is_last;
  } req_t;

  typedef struct packed {
    logic [15:0] q_value;
    logic [3:0]  out_index;
    logic        last_out;
    logic        saturated;
  } res_t;
endpackage

// File: design/mlpf_ram.sv
// mlpf_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module mlpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/mlpf_front.sv
// mlpf_front: accepts requests, drops unused codes, queues the rest.
// Depends on mlpf_pkg.
module mlpf_front #(
  parameter int QDEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  mlpf_pkg::req_t  req_in,
  output logic            q_valid,
  input  logic            q_take,
  output mlpf_pkg::req_t  q_req
);
  localparam int AW = $clog2(QDEPTH);
  mlpf_pkg::req_t buf_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          wr;

  assign full    = (cnt_r == (AW+1)'(QDEPTH));
  assign wr      = push && !full && (req_in.func != mlpf_pkg::FUNC_NONE);
  assign q_valid = (cnt_r != '0);
  assign q_req   = buf_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !(q_take && q_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!wr && q_take && q_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr) buf_r[wp_r] <= req_in;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (q_take && q_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

// File: design/mlpf_back.sv
// mlpf_back: parameter stores, MAC sequencer and result queue.
// Depends on mlpf_pkg and mlpf_ram.
module mlpf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_take,
  input  mlpf_pkg::req_t       q_req,
  input  logic [2:0]           layer_count,
  input  logic [4:0]           input_width,
  input  logic [4*5-1:0]       out_widths,
  output logic                 empty,
  input  logic                 pop,
  output mlpf_pkg::res_t       res
);
  localparam int MAX_LAYERS = mlpf_pkg::MAX_LAYERS;
  localparam int MAX_WIDTH  = mlpf_pkg::MAX_WIDTH;
  localparam int DATA_WIDTH = mlpf_pkg::DATA_WIDTH;
  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int NW = $clog2(MAX_WIDTH);
  localparam int WAW = LW + 2*NW;
  localparam int BAW = LW + NW;
  localparam int ACCW = 2*DATA_WIDTH + NW + 2;
  localparam int RQD = 16;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_LOAD = 5'b00010, S_MAC = 5'b00100,
    S_BIAS = 5'b01000, S_DONE = 5'b10000
  } st_t;
  st_t st_r;

  logic [LW-1:0] l_r, lmax_r;
  logic [NW-1:0] n_r, i_r, nmax_r, imax_r;
  logic          bank_r, rd_v_r, rd_last_r;
  logic signed [ACCW-1:0] acc_r;

  // stores
  logic w_we, b_we, s_we, a_we;
  logic [WAW-1:0] w_ra;
  logic [BAW-1:0] b_ra;
  logic [NW-1:0]  s_ra;
  logic [NW:0]    a_ra, a_wa;
  logic [DATA_WIDTH-1:0] w_rd, b_rd, s_rd, a_rd, a_wd;
  logic fromsample_r;

  logic acc_ok;
  assign acc_ok = q_req.layer_sel < MAX_LAYERS && q_req.node_sel < MAX_WIDTH
                  && q_req.elem_index < MAX_WIDTH;
  assign w_we = (st_r == S_IDLE) && q_valid && q_req.func == mlpf_pkg::FUNC_WEIGHT && acc_ok;
  assign b_we = (st_r == S_IDLE) && q_valid && q_req.func == mlpf_pkg::FUNC_BIAS && acc_ok;
  assign s_we = (st_r == S_IDLE) && q_valid && q_req.func == mlpf_pkg::FUNC_SAMPLE;

  mlpf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_LAYERS*MAX_WIDTH*MAX_WIDTH)) u_w (
    .clk, .we(w_we),
    .waddr({q_req.layer_sel[LW-1:0], q_req.node_sel[NW-1:0], q_req.elem_index[NW-1:0]}),
    .wdata(q_req.value[DATA_WIDTH-1:0]), .raddr(w_ra), .rdata(w_rd));
  mlpf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_LAYERS*MAX_WIDTH)) u_b (
    .clk, .we(b_we), .waddr({q_req.layer_sel[LW-1:0], q_req.node_sel[NW-1:0]}),
    .wdata(q_req.value[DATA_WIDTH-1:0]), .raddr(b_ra), .rdata(b_rd));
  mlpf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_WIDTH)) u_s (
    .clk, .we(s_we), .waddr(q_req.elem_index[NW-1:0]),
    .wdata(q_req.value[DATA_WIDTH-1:0]), .raddr(s_ra), .rdata(s_rd));
  mlpf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(2*MAX_WIDTH)) u_a (
    .clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));

  assign w_ra = {l_r, n_r, i_r};
  assign b_ra = {l_r, n_r};
  assign s_ra = i_r;
  assign a_ra = {~bank_r, i_r};

  // clamped widths
  function automatic logic [NW-1:0] wclamp(input logic [4:0] v);
    if (v == 5'd0) return '0;
    if (32'(v) > MAX_WIDTH) return NW'(MAX_WIDTH-1);
    return NW'(v - 5'd1);
  endfunction

  logic [4:0] ow_sel;
  assign ow_sel = out_widths[5*l_r +: 5];

  // result queue
  mlpf_pkg::res_t rq_r [RQD];
  logic [3:0] rwp_r, rrp_r;
  logic [4:0] rcnt_r;
  logic       r_push;
  mlpf_pkg::res_t r_item;
  assign empty = (rcnt_r == '0);
  assign res = rq_r[rrp_r];

  // finishing a node
  logic signed [ACCW-1:0] tot, sh;
  logic signed [DATA_WIDTH-1:0] sum;
  logic clamped;
  localparam logic signed [ACCW-1:0] HI = ACCW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
  localparam logic signed [ACCW-1:0] LO = -HI - 1;
  logic final_l;
  assign final_l = (l_r == lmax_r);
  always_comb begin
    tot = acc_r + (ACCW'($signed(b_rd)) <<< mlpf_pkg::FRAC_BITS);
    sh = tot >>> mlpf_pkg::FRAC_BITS;
    clamped = (sh > HI) || (sh < LO);
    sum = (sh > HI) ? HI[DATA_WIDTH-1:0] : (sh < LO) ? LO[DATA_WIDTH-1:0]
          : sh[DATA_WIDTH-1:0];
    r_item.q_value = 16'(sum);
    r_item.out_index = 4'(n_r);
    r_item.last_out = (n_r == nmax_r);
    r_item.saturated = clamped;
  end
  assign r_push = (st_r == S_BIAS) && final_l;
  assign a_we = (st_r == S_BIAS) && !final_l;
  assign a_wa = {bank_r, n_r};
  assign a_wd = (sum > 0) ? sum : '0;

  // a pass starts only when the result queue is empty, so it never overflows
  assign q_take = (st_r == S_IDLE) && q_valid &&
    !(q_req.func == mlpf_pkg::FUNC_SAMPLE && q_req.is_last && !empty);

  logic [LW-1:0] lc;
  assign lc = (layer_count == 3'd0) ? '0 : (32'(layer_count) > MAX_LAYERS)
              ? LW'(MAX_LAYERS-1) : LW'(layer_count - 3'd1);

  always_ff @(posedge clk) begin
    if (r_push) rq_r[rwp_r] <= r_item;
    if (!rst_n) begin
      st_r <= S_IDLE; rwp_r <= '0; rrp_r <= '0; rcnt_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (r_push) rwp_r <= rwp_r + 1'b1;
      if (pop && !empty) rrp_r <= rrp_r + 1'b1;
      rcnt_r <= rcnt_r + 5'(r_push) - 5'(pop && !empty);
      case (st_r)
        S_IDLE: begin
          if (q_take && q_req.func == mlpf_pkg::FUNC_SAMPLE && q_req.is_last) begin
            st_r <= S_LOAD; l_r <= '0; n_r <= '0; i_r <= '0; bank_r <= 1'b0;
            lmax_r <= lc; imax_r <= wclamp(input_width); fromsample_r <= 1'b1;
          end
        end
        S_LOAD: begin
          // input 0 is read this cycle, input 1 goes out in the first MAC cycle
          nmax_r <= wclamp(ow_sel);
          acc_r <= '0; st_r <= S_MAC;
          rd_v_r <= 1'b1; rd_last_r <= (imax_r == '0);
          if (imax_r != '0) i_r <= NW'(1);
        end
        S_MAC: begin
          // product of the previous read accumulates, the read at i_r goes out
          if (rd_v_r) begin
            acc_r <= acc_r + ACCW'($signed(fromsample_r ? s_rd : a_rd) * $signed(w_rd));
            if (rd_last_r) st_r <= S_BIAS;
          end
          rd_v_r <= rd_v_r && !rd_last_r;
          if (rd_v_r && !rd_last_r) begin
            rd_last_r <= (i_r == imax_r);
            if (i_r != imax_r) i_r <= i_r + 1'b1;
          end
        end
        S_BIAS: begin
          i_r <= '0;
          if (n_r != nmax_r) begin
            n_r <= n_r + 1'b1; st_r <= S_LOAD;
          end else if (!final_l) begin
            n_r <= '0; l_r <= l_r + 1'b1; bank_r <= ~bank_r;
            imax_r <= nmax_r; fromsample_r <= 1'b0; st_r <= S_LOAD;
          end else begin
            st_r <= S_DONE;
          end
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/mlp_forward_relu.sv
// mlp_forward_relu: top level of the fully connected MLP inference block.
// Depends on mlpf_pkg, mlpf_front, mlpf_back, mlpf_ram.
//
// Weight, bias and sample requests enter through a small front queue and are
// applied by a back end holding the parameter memories; a request is
// registered in the front queue before it reaches the back end. A sample
// request with in_is_last starts a pass; the single MAC unit then steps
// each node through read setup, a multiply-accumulate for each weight, then
// bias and write-back. Requests are taken only while the back end is idle.
// The final layer's node values come out through a 16-entry result queue,
// one per pop, the last one marked by out_last_out. Q8.8 arithmetic, floor
// rounding, 16-bit saturation; ReLU on hidden layers.
module mlp_forward_relu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_layer_sel,
  input  logic [3:0]  in_node_sel,
  input  logic [3:0]  in_elem_index,
  input  logic signed [15:0] in_value,
  input  logic        in_is_last,
  output logic        empty,
  input  logic        pop,
  output logic signed [15:0] out_q_value,
  output logic [3:0]  out_index,
  output logic        out_last_out,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);
  mlpf_pkg::req_t req, q_req;
  mlpf_pkg::res_t res;
  logic q_valid, q_take;

  logic [2:0]  layer_count_r;
  logic [4:0]  input_width_r;
  logic [19:0] out_widths_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= 3'd2;
      input_width_r <= 5'd16;
      out_widths_r  <= {4{5'd16}};
    end else if (cfg_we) begin
      case (cfg_index)
        mlpf_pkg::REG_LAYER_COUNT: layer_count_r <= cfg_wdata[2:0];
        mlpf_pkg::REG_INPUT_WIDTH: input_width_r <= cfg_wdata;
        default: begin
          if (cfg_index inside {[mlpf_pkg::REG_OUT_WIDTH_0:mlpf_pkg::REG_OUT_WIDTH_3]})
            out_widths_r[5*(cfg_index - mlpf_pkg::REG_OUT_WIDTH_0) +: 5] <= cfg_wdata;
        end
      endcase
    end
  end

  assign req = '{func: in_func, layer_sel: in_layer_sel, node_sel: in_node_sel,
                 elem_index: in_elem_index, value: in_value, is_last: in_is_last};

  mlpf_front u_front (
    .clk, .rst_n, .push, .full, .req_in(req),
    .q_valid, .q_take, .q_req);

  mlpf_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_req,
    .layer_count(layer_count_r), .input_width(input_width_r),
    .out_widths(out_widths_r), .empty, .pop, .res);

  assign out_q_value   = res.q_value;
  assign out_index     = res.out_index;
  assign out_last_out  = res.last_out;
  assign out_saturated = res.saturated;
endmodule
